FILE: rtl/rdi_pkg.sv
package rdi_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON  = 3'd7;

  // Hit status codes
  localparam logic [1:0] ST_MISS  = 2'd0;
  localparam logic [1:0] ST_BACK  = 2'd1;
  localparam logic [1:0] ST_FRONT = 2'd2;

  // Field widths
  localparam int CW = 32;   // coordinate
  localparam int NW = 18;   // unit vector component
  localparam int DIST_W = 31;
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

endpackage

FILE: rtl/rdi_div.sv
module rdi_div #(
  parameter int DW = 38,
  parameter int QW = 31,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [DW-1:0] rem_in,
  input  logic [QW-1:0] low_in,
  input  logic [DW-1:0] den_in,
  input  logic [PW-1:0] pay_in,
  output logic          vld_out,
  output logic [QW-1:0] quo,
  output logic [PW-1:0] pay_out
);

  // One quotient bit per stage; remainder stays below the divisor
  logic          vld [1:QW];
  logic [DW-1:0] rem [1:QW];
  logic [QW-1:0] low [1:QW];
  logic [QW-1:0] qacc [1:QW];
  logic [DW-1:0] den [1:QW];
  logic [PW-1:0] pay [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          c_vld;
    logic [DW-1:0] c_rem;
    logic [QW-1:0] c_low;
    logic [QW-1:0] c_q;
    logic [DW-1:0] c_den;
    logic [PW-1:0] c_pay;
    logic [DW:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign c_vld = vld_in;
      assign c_rem = rem_in;
      assign c_low = low_in;
      assign c_q   = '0;
      assign c_den = den_in;
      assign c_pay = pay_in;
    end else begin : g_next
      assign c_vld = vld[j];
      assign c_rem = rem[j];
      assign c_low = low[j];
      assign c_q   = qacc[j];
      assign c_den = den[j];
      assign c_pay = pay[j];
    end

    // Shift in the next dividend bit and try the subtract
    assign trial = {c_rem, c_low[QW-1]};
    assign ge    = trial >= {1'b0, c_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? DW'(trial - {1'b0, c_den}) : DW'(trial);
        low[j+1]  <= {c_low[QW-2:0], 1'b0};
        qacc[j+1] <= {c_q[QW-2:0], ge};
        den[j+1]  <= c_den;
        pay[j+1]  <= c_pay;
      end
    end
  end

  assign vld_out = vld[QW];
  assign quo     = qacc[QW];
  assign pay_out = pay[QW];

endmodule

FILE: rtl/rdi_sqrt.sv
module rdi_sqrt #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [63:0]   rad_in,
  input  logic [PW-1:0] pay_in,
  output logic          vld_out,
  output logic [31:0]   root_out,
  output logic [PW-1:0] pay_out
);

  // One root bit per stage, two radicand bits consumed each step
  logic          vld [1:32];
  logic [34:0]   rem [1:32];
  logic [31:0]   root [1:32];
  logic [63:0]   xs [1:32];
  logic [PW-1:0] pay [1:32];

  for (genvar j = 0; j < 32; j++) begin : g_stage
    logic          c_vld;
    logic [34:0]   c_rem;
    logic [31:0]   c_root;
    logic [63:0]   c_x;
    logic [PW-1:0] c_pay;
    logic [34:0]   tmp;
    logic [34:0]   trial;
    logic          ge;

    if (j == 0) begin : g_first
      assign c_vld  = vld_in;
      assign c_rem  = '0;
      assign c_root = '0;
      assign c_x    = rad_in;
      assign c_pay  = pay_in;
    end else begin : g_next
      assign c_vld  = vld[j];
      assign c_rem  = rem[j];
      assign c_root = root[j];
      assign c_x    = xs[j];
      assign c_pay  = pay[j];
    end

    assign tmp   = {c_rem[32:0], c_x[63:62]};
    assign trial = {1'b0, c_root, 2'b01};
    assign ge    = tmp >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? (tmp - trial) : tmp;
        root[j+1] <= {c_root[30:0], ge};
        xs[j+1]   <= {c_x[61:0], 2'b00};
        pay[j+1]  <= c_pay;
      end
    end
  end

  assign vld_out  = vld[32];
  assign root_out = root[32];
  assign pay_out  = pay[32];

endmodule

FILE: rtl/ray_disk_intersect_unit.sv
// Channel | Valid     | Stall     | Payload
// ray     | ray_valid | ray_stall | origin_x/y/z, dir_x/y/z, best_dist, simple_query
// hit     | hit_valid | hit_stall | hit_status, hit_dist, hit_x/y/z, surf_nx/ny/nz, radial_frac
// config  | cfg_we    | (none)    | cfg_index, cfg_data
//
// One ray enters every cycle unless ray_stall is high.
// The pipeline holds the 31-stage distance divider, the 32-stage square root
// and the 17-stage radial divider, each resolving one bit per stage.
// A stalled result freezes the whole pipeline; ray_stall follows it directly.
// Reset clears all valid bits and loads the disk registers with their defaults.
module ray_disk_intersect_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rdi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               ray_valid,
  output logic                               ray_stall,
  input  logic signed [31:0]                 origin_x,
  input  logic signed [31:0]                 origin_y,
  input  logic signed [31:0]                 origin_z,
  input  logic signed [17:0]                 dir_x,
  input  logic signed [17:0]                 dir_y,
  input  logic signed [17:0]                 dir_z,
  input  logic signed [31:0]                 best_dist,
  input  logic                               simple_query,
  output logic                               hit_valid,
  input  logic                               hit_stall,
  output logic [1:0]                         hit_status,
  output logic [30:0]                        hit_dist,
  output logic signed [31:0]                 hit_x,
  output logic signed [31:0]                 hit_y,
  output logic signed [31:0]                 hit_z,
  output logic signed [17:0]                 surf_nx,
  output logic signed [17:0]                 surf_ny,
  output logic signed [17:0]                 surf_nz,
  output logic [16:0]                        radial_frac
);
  import rdi_pkg::*;

  localparam int HIT_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
  localparam logic signed [33:0] HIT_HI = (34'sd1 <<< (HIT_BITS - 1)) - 34'sd1;
  localparam logic signed [33:0] HIT_LO = -HIT_HI - 34'sd1;

  typedef struct packed {
    logic            miss;
    logic            back;
    logic            simple;
    logic [2:0][31:0] o;
    logic [2:0][17:0] v;
    logic [31:0]     best;
  } ray_pay_t;

  typedef struct packed {
    logic            miss;
    logic            back;
    logic            simple;
    logic [30:0]     t;
    logic [2:0][33:0] p;
  } hit_pay_t;

  function automatic logic signed [17:0] neg_sat(input logic signed [17:0] n);
    logic signed [17:0] r;
    if (n == -18'sd131072) r = 18'sd131071;
    else r = -n;
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_hit(input logic signed [33:0] p);
    logic signed [33:0] c;
    if (p > HIT_HI) c = HIT_HI;
    else if (p < HIT_LO) c = HIT_LO;
    else c = p;
    return c[31:0];
  endfunction

  // Disk registers
  logic signed [31:0] ctr [3];
  logic signed [17:0] nrm [3];
  logic [30:0]        disk_radius;
  logic [15:0]        epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr[0] <= '0;
      ctr[1] <= '0;
      ctr[2] <= '0;
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= 18'sd65536;
      disk_radius <= 31'd65536;
      epsilon <= 16'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X: ctr[0] <= cfg_data;
        CFG_CENTER_Y: ctr[1] <= cfg_data;
        CFG_CENTER_Z: ctr[2] <= cfg_data;
        CFG_NORMAL_X: nrm[0] <= cfg_data[17:0];
        CFG_NORMAL_Y: nrm[1] <= cfg_data[17:0];
        CFG_NORMAL_Z: nrm[2] <= cfg_data[17:0];
        CFG_RADIUS:   disk_radius <= cfg_data[30:0];
        CFG_EPSILON:  epsilon <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [31:0] eps32;
  assign eps32 = {epsilon, 16'b0};

  // Global advance: hold everything while a result waits
  logic en;
  assign en        = !(hit_valid && hit_stall);
  assign ray_stall = hit_valid && hit_stall;

  logic signed [31:0] o_in [3];
  logic signed [17:0] v_in [3];
  assign o_in[0] = origin_x;
  assign o_in[1] = origin_y;
  assign o_in[2] = origin_z;
  assign v_in[0] = dir_x;
  assign v_in[1] = dir_y;
  assign v_in[2] = dir_z;

  // Stage 1: centre offsets and n.v terms
  logic               s1_valid;
  logic signed [31:0] s1_o [3];
  logic signed [17:0] s1_v [3];
  logic signed [32:0] s1_diff [3];
  logic signed [35:0] s1_nv [3];
  logic signed [31:0] s1_best;
  logic               s1_simple;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= ray_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_o[k]    <= o_in[k];
        s1_v[k]    <= v_in[k];
        s1_diff[k] <= 33'(ctr[k]) - 33'(o_in[k]);
        s1_nv[k]   <= nrm[k] * v_in[k];
      end
      s1_best   <= best_dist;
      s1_simple <= simple_query;
    end
  end

  // Stage 2: n.(c - o) terms and the denominator sum
  logic               s2_valid;
  logic signed [31:0] s2_o [3];
  logic signed [17:0] s2_v [3];
  logic signed [50:0] s2_nd [3];
  logic signed [37:0] s2_bot;
  logic signed [31:0] s2_best;
  logic               s2_simple;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_o[k]  <= s1_o[k];
        s2_v[k]  <= s1_v[k];
        s2_nd[k] <= s1_diff[k] * nrm[k];
      end
      s2_bot    <= 38'(s1_nv[0]) + 38'(s1_nv[1]) + 38'(s1_nv[2]);
      s2_best   <= s1_best;
      s2_simple <= s1_simple;
    end
  end

  // Stage 3: numerator, magnitudes, degenerate and range checks
  logic signed [52:0] top;
  logic [52:0]        ut;
  logic [37:0]        ub;
  logic               miss3;
  logic               back3;

  always_comb begin
    top   = 53'(s2_nd[0]) + 53'(s2_nd[1]) + 53'(s2_nd[2]);
    ut    = top[52] ? 53'(-top) : 53'(top);
    ub    = s2_bot[37] ? 38'(-s2_bot) : 38'(s2_bot);
    miss3 = (ub == '0) || (ut < {21'b0, eps32}) || (ub < {6'b0, eps32}) ||
            ((top != '0) && (top[52] != s2_bot[37])) ||
            (ut[52:15] >= ub);
    back3 = s2_bot > $signed({6'b0, eps32});
  end

  logic        s3_valid;
  logic [37:0] s3_rem;
  logic [30:0] s3_low;
  logic [37:0] s3_den;
  ray_pay_t    s3_pay;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_rem <= ut[52:15];
      s3_low <= {ut[14:0], 16'b0};
      s3_den <= ub;
      s3_pay.miss   <= miss3;
      s3_pay.back   <= back3;
      s3_pay.simple <= s2_simple;
      for (int k = 0; k < 3; k++) begin
        s3_pay.o[k] <= s2_o[k];
        s3_pay.v[k] <= s2_v[k];
      end
      s3_pay.best <= s2_best;
    end
  end

  // Distance divider: t = |top| * 2^16 / |bot|
  logic        dv_valid;
  logic [30:0] dv_t;
  ray_pay_t    dv_pay;

  rdi_div #(.DW(38), .QW(DIST_W), .PW($bits(ray_pay_t))) u_tdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (s3_valid),
    .rem_in  (s3_rem),
    .low_in  (s3_low),
    .den_in  (s3_den),
    .pay_in  (s3_pay),
    .vld_out (dv_valid),
    .quo     (dv_t),
    .pay_out (dv_pay)
  );

  // Stage A: near and best-distance checks, t*v
  logic               sa_valid;
  logic               sa_miss, sa_back, sa_simple;
  logic [30:0]        sa_t;
  logic signed [31:0] sa_o [3];
  logic signed [49:0] sa_tv [3];

  always_ff @(posedge clk) begin
    if (rst) sa_valid <= 1'b0;
    else if (en) sa_valid <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_miss <= dv_pay.miss || (dv_t < 31'(epsilon)) ||
                 !(dv_pay.best[31] || ({1'b0, dv_t} < dv_pay.best));
      sa_back   <= dv_pay.back;
      sa_simple <= dv_pay.simple;
      sa_t      <= dv_t;
      for (int k = 0; k < 3; k++) begin
        sa_o[k]  <= dv_pay.o[k];
        sa_tv[k] <= $signed({1'b0, dv_t}) * $signed(dv_pay.v[k]);
      end
    end
  end

  // Stage B: hit point
  logic               sb_valid;
  logic               sb_miss, sb_back, sb_simple;
  logic [30:0]        sb_t;
  logic signed [33:0] sb_p [3];

  always_ff @(posedge clk) begin
    if (rst) sb_valid <= 1'b0;
    else if (en) sb_valid <= sa_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_miss   <= sa_miss;
      sb_back   <= sa_back;
      sb_simple <= sa_simple;
      sb_t      <= sa_t;
      for (int k = 0; k < 3; k++) begin
        sb_p[k] <= 34'(sa_o[k]) + 34'(sa_tv[k] >>> 16);
      end
    end
  end

  // Stage C: offset from centre, per-axis radius check
  logic               sc_valid;
  logic               sc_miss, sc_back, sc_simple;
  logic [30:0]        sc_t;
  logic signed [33:0] sc_p [3];
  logic [30:0]        sc_ad [3];
  logic signed [34:0] dc [3];
  logic [34:0]        adc [3];
  logic               far;

  always_comb begin
    far = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dc[k]  = 35'(sb_p[k]) - 35'(ctr[k]);
      adc[k] = dc[k][34] ? 35'(-dc[k]) : 35'(dc[k]);
      far    = far || (adc[k] > {4'b0, disk_radius});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) sc_valid <= 1'b0;
    else if (en) sc_valid <= sb_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_miss   <= sb_miss || far;
      sc_back   <= sb_back;
      sc_simple <= sb_simple;
      sc_t      <= sb_t;
      for (int k = 0; k < 3; k++) begin
        sc_p[k]  <= sb_p[k];
        sc_ad[k] <= adc[k][30:0];
      end
    end
  end

  // Stage D: squares
  logic               sd_valid;
  logic               sd_miss, sd_back, sd_simple;
  logic [30:0]        sd_t;
  logic signed [33:0] sd_p [3];
  logic [61:0]        sd_sq [3];
  logic [61:0]        sd_rad2;

  always_ff @(posedge clk) begin
    if (rst) sd_valid <= 1'b0;
    else if (en) sd_valid <= sc_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_miss   <= sc_miss;
      sd_back   <= sc_back;
      sd_simple <= sc_simple;
      sd_t      <= sc_t;
      for (int k = 0; k < 3; k++) begin
        sd_p[k]  <= sc_p[k];
        sd_sq[k] <= sc_ad[k] * sc_ad[k];
      end
      sd_rad2 <= disk_radius * disk_radius;
    end
  end

  // Stage E: squared distance and the disk test
  logic [63:0] sum_e;
  assign sum_e = 64'(sd_sq[0]) + 64'(sd_sq[1]) + 64'(sd_sq[2]);

  logic        se_valid;
  logic [63:0] se_sum;
  hit_pay_t    se_pay;

  always_ff @(posedge clk) begin
    if (rst) se_valid <= 1'b0;
    else if (en) se_valid <= sd_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      se_sum        <= sum_e;
      se_pay.miss   <= sd_miss || (sum_e > 64'(sd_rad2));
      se_pay.back   <= sd_back;
      se_pay.simple <= sd_simple;
      se_pay.t      <= sd_t;
      for (int k = 0; k < 3; k++) begin
        se_pay.p[k] <= sd_p[k];
      end
    end
  end

  // Square root of the squared distance
  logic        sq_valid;
  logic [31:0] sq_root;
  hit_pay_t    sq_pay;

  rdi_sqrt #(.PW($bits(hit_pay_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vld_in   (se_valid),
    .rad_in   (se_sum),
    .pay_in   (se_pay),
    .vld_out  (sq_valid),
    .root_out (sq_root),
    .pay_out  (sq_pay)
  );

  // Radial fraction: root * 2^16 / radius
  logic        fr_valid;
  logic [16:0] fr_q;
  hit_pay_t    fr_pay;

  rdi_div #(.DW(31), .QW(FRAC_W), .PW($bits(hit_pay_t))) u_fdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (sq_valid),
    .rem_in  (sq_root[31:1]),
    .low_in  ({sq_root[0], 16'b0}),
    .den_in  (disk_radius),
    .pay_in  (sq_pay),
    .vld_out (fr_valid),
    .quo     (fr_q),
    .pay_out (fr_pay)
  );

  // Output register: drop details on a miss or a simple request
  always_ff @(posedge clk) begin
    if (rst) hit_valid <= 1'b0;
    else if (en) hit_valid <= fr_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fr_pay.miss || fr_pay.simple) begin
        hit_status  <= fr_pay.miss ? ST_MISS : ST_BACK;
        hit_dist    <= '0;
        hit_x       <= '0;
        hit_y       <= '0;
        hit_z       <= '0;
        surf_nx     <= '0;
        surf_ny     <= '0;
        surf_nz     <= '0;
        radial_frac <= '0;
      end else begin
        hit_status  <= fr_pay.back ? ST_BACK : ST_FRONT;
        hit_dist    <= fr_pay.t;
        hit_x       <= clamp_hit(fr_pay.p[0]);
        hit_y       <= clamp_hit(fr_pay.p[1]);
        hit_z       <= clamp_hit(fr_pay.p[2]);
        surf_nx     <= fr_pay.back ? neg_sat(nrm[0]) : nrm[0];
        surf_ny     <= fr_pay.back ? neg_sat(nrm[1]) : nrm[1];
        surf_nz     <= fr_pay.back ? neg_sat(nrm[2]) : nrm[2];
        if (disk_radius == '0) radial_frac <= '0;
        else if (fr_q > FRAC_ONE) radial_frac <= FRAC_ONE;
        else radial_frac <= fr_q;
      end
    end
  end

endmodule

FILE: rtl/rdi_check.sv
module rdi_check (
  input logic        clk,
  input logic        rst,
  input logic        ray_valid,
  input logic        ray_stall,
  input logic        hit_valid,
  input logic        hit_stall,
  input logic [1:0]  hit_status,
  input logic [30:0] hit_dist
);
  import rdi_pkg::*;

  // Nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !hit_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    hit_valid && hit_stall |=> hit_valid && $stable(hit_status) && $stable(hit_dist))
    else $error("stalled result changed");

  // Requests are refused only while a result is held
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !(hit_valid && hit_stall) |-> !ray_stall)
    else $error("request stalled without output back-pressure");

  // Misses carry no distance
  a_no_dist: assert property (@(posedge clk) disable iff (rst)
    hit_valid && (hit_status == ST_MISS || ray_valid && 1'b0) |-> hit_dist == '0)
    else $error("miss carries a distance");

  // Only defined status codes leave the block
  a_status: assert property (@(posedge clk) disable iff (rst)
    hit_valid |-> hit_status == ST_MISS || hit_status == ST_BACK || hit_status == ST_FRONT)
    else $error("undefined hit status");

endmodule

bind ray_disk_intersect_unit rdi_check u_rdi_check (.*);

FILE: sim/ray_disk_checker.sv
module ray_disk_checker
  import rdi_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]              cfg_data,
  input  logic                     ray_valid,
  input  logic                     ray_stall,
  input  logic signed [31:0]       origin_x,
  input  logic signed [31:0]       origin_y,
  input  logic signed [31:0]       origin_z,
  input  logic signed [17:0]       dir_x,
  input  logic signed [17:0]       dir_y,
  input  logic signed [17:0]       dir_z,
  input  logic signed [31:0]       best_dist,
  input  logic                     simple_query,
  input  logic                     hit_valid,
  input  logic                     hit_stall,
  input  logic [1:0]               hit_status,
  input  logic [30:0]              hit_dist,
  input  logic signed [31:0]       hit_x,
  input  logic signed [31:0]       hit_y,
  input  logic signed [31:0]       hit_z,
  input  logic signed [17:0]       surf_nx,
  input  logic signed [17:0]       surf_ny,
  input  logic signed [17:0]       surf_nz,
  input  logic [16:0]              radial_frac,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         status;
    logic [30:0]        hdist;
    logic signed [31:0] px, py, pz;
    logic signed [17:0] nx, ny, nz;
    logic [16:0]        frac;
  } hit_t;

  hit_t hit_queue[$];

  // Disk registers as the block should hold them
  logic signed [31:0] disk_c[3];
  logic signed [17:0] disk_n[3];
  logic [30:0]        disk_rad;
  logic [15:0]        disk_eps;

  assign pending = hit_queue.size();

  function automatic longint floor16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint clamp_s(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic hit_t trace_disk(logic signed [31:0] o[3], logic signed [17:0] v[3],
                                      logic signed [31:0] best, logic simple);
    hit_t h;
    longint top, bot, p[3], d, nn[3];
    longint unsigned ut, ub, eps, rad, q, t, sum, frac;
    h = '0;
    top = 0;
    bot = 0;
    sum = 0;
    frac = 0;
    rad = disk_rad;
    eps = longint'(disk_eps) << 16;
    for (int k = 0; k < 3; k++) begin
      top += longint'(disk_n[k]) * (longint'(disk_c[k]) - longint'(o[k]));
      bot += longint'(disk_n[k]) * longint'(v[k]);
      nn[k] = disk_n[k];
    end
    ut = top < 0 ? -top : top;
    ub = bot < 0 ? -bot : bot;
    if (ub == 0 || ut < eps || ub < eps) return h;
    if (top != 0 && ((top < 0) != (bot < 0))) return h;
    q = ut / ub;
    if (q >= 32768) return h;
    t = (q << 16) + ((ut % ub) << 16) / ub;
    if (t < (eps >> 16)) return h;
    for (int k = 0; k < 3; k++) begin
      p[k] = longint'(o[k]) + floor16(longint'(t) * longint'(v[k]));
      d = p[k] - longint'(disk_c[k]);
      if (d < 0) d = -d;
      if (longint'(d) > longint'(rad)) return h;
      sum += d * d;
    end
    if (sum > rad * rad) return h;
    if (!(best < 0 || longint'(t) < longint'(best))) return h;
    if (simple) begin
      h.status = ST_BACK;
      return h;
    end
    if (rad != 0) begin
      frac = (root64(sum) << 16) / rad;
      if (frac > 65536) frac = 65536;
    end
    h.status = ST_FRONT;
    if (bot > longint'(eps)) begin
      h.status = ST_BACK;
      for (int k = 0; k < 3; k++) nn[k] = clamp_s(-nn[k], 18);
    end
    h.hdist = t[30:0];
    h.px = 32'(clamp_s(p[0], 32));
    h.py = 32'(clamp_s(p[1], 32));
    h.pz = 32'(clamp_s(p[2], 32));
    h.nx = 18'(nn[0]);
    h.ny = 18'(nn[1]);
    h.nz = 18'(nn[2]);
    h.frac = frac[16:0];
    return h;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    hit_t want, got;
    logic signed [31:0] o[3];
    logic signed [17:0] v[3];
    if (rst) begin
      disk_c = '{0, 0, 0};
      disk_n = '{0, 0, 65536};
      disk_rad = 31'd65536;
      disk_eps = 16'd1;
      errors = 0;
      hit_queue.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTER_X: disk_c[0] = cfg_data;
          CFG_CENTER_Y: disk_c[1] = cfg_data;
          CFG_CENTER_Z: disk_c[2] = cfg_data;
          CFG_NORMAL_X: disk_n[0] = cfg_data[17:0];
          CFG_NORMAL_Y: disk_n[1] = cfg_data[17:0];
          CFG_NORMAL_Z: disk_n[2] = cfg_data[17:0];
          CFG_RADIUS:   disk_rad = cfg_data[30:0];
          CFG_EPSILON:  disk_eps = cfg_data[15:0];
          default: ;
        endcase
      end
      // Predict each accepted request
      if (ray_valid && !ray_stall) begin
        o = '{origin_x, origin_y, origin_z};
        v = '{dir_x, dir_y, dir_z};
        hit_queue.push_back(trace_disk(o, v, best_dist, simple_query));
      end
      // Compare each accepted result
      if (hit_valid && !hit_stall) begin
        got = '{hit_status, hit_dist, hit_x, hit_y, hit_z, surf_nx, surf_ny, surf_nz,
                radial_frac};
        if (hit_queue.size() == 0) begin
          report_mismatch("unexpected result", hit_status, -1);
        end else begin
          want = hit_queue.pop_front();
          if (got.status != want.status) report_mismatch("hit_status", got.status, want.status);
          if (got.hdist != want.hdist) report_mismatch("hit_dist", got.hdist, want.hdist);
          if (got.px != want.px) report_mismatch("hit_x", got.px, want.px);
          if (got.py != want.py) report_mismatch("hit_y", got.py, want.py);
          if (got.pz != want.pz) report_mismatch("hit_z", got.pz, want.pz);
          if (got.nx != want.nx) report_mismatch("surf_nx", got.nx, want.nx);
          if (got.ny != want.ny) report_mismatch("surf_ny", got.ny, want.ny);
          if (got.nz != want.nz) report_mismatch("surf_nz", got.nz, want.nz);
          if (got.frac != want.frac) report_mismatch("radial_frac", got.frac, want.frac);
        end
      end
    end
  end
endmodule

FILE: sim/testbench.sv
module testbench;
  import rdi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic ray_valid, ray_stall;
  logic signed [31:0] origin_x, origin_y, origin_z, best_dist;
  logic signed [17:0] dir_x, dir_y, dir_z;
  logic simple_query;
  logic hit_valid, hit_stall;
  logic [1:0] hit_status;
  logic [30:0] hit_dist;
  logic signed [31:0] hit_x, hit_y, hit_z;
  logic signed [17:0] surf_nx, surf_ny, surf_nz;
  logic [16:0] radial_frac;
  int errors, pending;
  int send_idle, recv_stall;

  ray_disk_intersect_unit dut (.*);
  ray_disk_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  // Random receiver stall
  always @(posedge clk) begin
    if (rst) hit_stall <= 1'b0;
    else hit_stall <= ($urandom_range(99) < recv_stall);
  end

  function automatic logic signed [17:0] rand_unit();
    case ($urandom_range(5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'sd0;
      3: return 18'($urandom);
      default: return $signed(18'($urandom_range(131072))) - 18'sd65536;
    endcase
  endfunction

  // Drive one register write; the caller drops the enable after the last one
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic set_disk(logic signed [31:0] cx, cy, cz, logic signed [17:0] nx, ny, nz,
                          logic [30:0] rad, logic [15:0] eps);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_NORMAL_X, 32'(nx));
    write_reg(CFG_NORMAL_Y, 32'(ny));
    write_reg(CFG_NORMAL_Z, 32'(nz));
    write_reg(CFG_RADIUS, 32'(rad));
    write_reg(CFG_EPSILON, 32'(eps));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    ray_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  // Offer one request and hold it until taken; valid stays up for a follower
  task automatic send_ray(logic signed [31:0] ox, oy, oz, logic signed [17:0] vx, vy, vz,
                          logic signed [31:0] best, logic simple);
    while ($urandom_range(99) < send_idle) begin
      ray_valid <= 1'b0;
      @(posedge clk);
    end
    ray_valid <= 1'b1;
    origin_x <= ox;
    origin_y <= oy;
    origin_z <= oz;
    dir_x <= vx;
    dir_y <= vy;
    dir_z <= vz;
    best_dist <= best;
    simple_query <= simple;
    @(posedge clk);
    while (ray_stall) @(posedge clk);
  endtask

  // Ray aimed near the disk centre, from either side
  task automatic aimed_ray(int spread);
    logic signed [31:0] tx, ty, tz, ox, oy, oz, best;
    logic signed [17:0] vx, vy, vz;
    int sel;
    tx = checker_i.disk_c[0] + $signed($urandom_range(2 * spread)) - spread;
    ty = checker_i.disk_c[1] + $signed($urandom_range(2 * spread)) - spread;
    tz = checker_i.disk_c[2];
    sel = $urandom_range(3);
    vx = sel == 0 ? 18'sd0 : $signed(18'($urandom_range(40000))) - 18'sd20000;
    vy = sel == 1 ? 18'sd0 : $signed(18'($urandom_range(40000))) - 18'sd20000;
    vz = $urandom_range(1) ? 18'sd60000 : -18'sd60000;
    ox = tx - 3 * vx;
    oy = ty - 3 * vy;
    oz = tz - 3 * vz;
    case ($urandom_range(3))
      0: best = $urandom;
      1: best = $urandom_range(400000);
      default: best = -1;
    endcase
    send_ray(ox, oy, oz, vx, vy, vz, best, $urandom_range(3) == 0);
  endtask

  task automatic random_ray();
    send_ray($urandom, $urandom, $urandom, rand_unit(), rand_unit(), rand_unit(),
             $urandom, 1'($urandom_range(1)));
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    ray_valid = 1'b0;
    origin_x = '0; origin_y = '0; origin_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0;
    best_dist = '0;
    simple_query = 1'b0;
    send_idle = 0;
    recv_stall = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset disk, unit radius at origin facing +z
    send_ray(0, 0, 32'sh20000, 0, 0, -18'sd65536, -1, 0);          // front hit at centre
    send_ray(0, 0, -32'sh20000, 0, 0, 18'sd65536, -1, 0);          // back hit
    send_ray(32'sh8000, 0, 32'sh20000, 0, 0, -18'sd65536, -1, 1);  // simple hit
    send_ray(32'sh20000, 0, 32'sh20000, 0, 0, -18'sd65536, -1, 0); // outside radius
    send_ray(0, 0, 32'sh20000, 18'sd65536, 0, 0, -1, 0);           // parallel
    send_ray(0, 0, 32'sh20000, 0, 0, 18'sd65536, -1, 0);           // pointing away
    send_ray(0, 0, 32'sh20000, 0, 0, -18'sd65536, 32'sh20000, 0);  // not nearer
    send_ray(0, 0, 32'sh20000, 0, 0, -18'sd65536, 32'sh20001, 0);  // just nearer
    send_ray(0, 0, 0, 0, 0, -18'sd65536, -1, 0);                   // origin on plane
    send_ray(0, 0, 32'sh7fffffff, 0, 0, -18'sd1, -1, 0);           // distance overflow
    send_ray(32'sh80000000, 32'sh7fffffff, 32'sh80000000, -18'sd131072, 18'sd131071,
             18'sd131071, 32'sh7fffffff, 0);
    send_ray(32'shffff, 0, 32'sh10000, 0, 0, -18'sd65536, -1, 0);  // rim
    drain();

    // Zero radius, out-of-range normal, big epsilon
    set_disk(32'sh10000, 0, 0, 0, 0, -18'sd131072, 0, 16'hffff);
    send_ray(32'sh10000, 0, 32'sh20000, 0, 0, -18'sd65536, -1, 0);
    send_ray(32'sh10000, 0, -32'sh20000, 0, 0, 18'sd65536, -1, 0);
    send_ray(32'sh10001, 0, 32'sh20000, 0, 0, -18'sd65536, -1, 0);
    drain();
    set_disk(0, 0, 0, 0, 0, 18'sd65536, 31'h7fffffff, 0);
    send_ray(0, 0, 32'sh10000, 0, 0, -18'sd65536, -1, 0);
    send_ray(32'sh7fffffff, 32'sh80000000, 32'sh10000, 0, 0, -18'sd65536, -1, 0);
    send_ray(0, 0, 32'sh10000, 18'sd65536, 0, 0, -1, 0);           // zero denominator
    drain();

    // Random phases with varied disks and idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 62; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 62; end
        default: begin send_idle = 12; recv_stall = 12; end
      endcase
      set_disk($signed($urandom_range(400000)) - 200000, $signed($urandom_range(400000)) - 200000,
               $urandom, ph[0] ? 18'sd0 : rand_unit(), 18'sd0,
               ph[1] ? 18'sd65536 : -18'sd65536,
               ph == 7 ? 31'h7fffffff : 31'($urandom_range(300000)),
               ph == 6 ? 16'hffff : 16'($urandom_range(3)));
      for (int i = 0; i < 105; i++) begin
        if ($urandom_range(3) == 0) random_ray();
        else aimed_ray($urandom_range(1) ? 100000 : 300000);
        if (ph == 2 && i == 50) begin
          ray_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
